// ===== hdl/max_on_time_purchases_defines.svh =====
// Assertion macros shared by the max_on_time_purchases RTL.
// No dependencies; files that check their own logic include this header.
`ifndef MAX_ON_TIME_PURCHASES_DEFINES_SVH
`define MAX_ON_TIME_PURCHASES_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Implication check, sampled on the rising clock edge and idle during reset.
`define MOT_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("max_on_time_purchases: check failed");
// Next-cycle check: the consequence must hold in the cycle after the antecedent.
`define MOT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("max_on_time_purchases: check failed");
`else
`define MOT_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons)
`define MOT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// ===== hdl/mot_pkg.sv =====
// Shared types and constants for the max_on_time_purchases block.
// No dependencies; used by mot_cell and the top level.
`timescale 1ns / 1ps
package mot_pkg;

  // Commands broadcast to every cell of the sorted chain.
  localparam logic [1:0] OP_HOLD    = 2'd0;
  localparam logic [1:0] OP_INSERT  = 2'd1;
  localparam logic [1:0] OP_REPLACE = 2'd2;

  // Result action codes.
  localparam logic [1:0] ACT_REJECT = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_SWAP   = 2'd2;

  // Fixed field widths of the stream payloads.
  localparam int FIELD_W      = 16;
  localparam int COUNT_OUT_W  = 7;
  localparam int TOTAL_OUT_W  = 16;
  localparam int ACTION_W     = 2;
  localparam int IN_TDATA_W   = 2 * FIELD_W;
  localparam int OUT_TDATA_W  = 24;
  localparam int OUT_PAD_W    = OUT_TDATA_W - COUNT_OUT_W - TOTAL_OUT_W;
  localparam int OUT_TUSER_W  = ACTION_W + 1;

  typedef struct packed {
    logic [1:0] op;
    logic       clr;
  } cell_cmd_t;

endpackage

// ===== hdl/mot_cell.sv =====
// One cell of the descending sorted cost chain of max_on_time_purchases.
// Depends on mot_pkg for the command struct and operation codes.
`timescale 1ns / 1ps
module mot_cell #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mot_pkg::cell_cmd_t    cmd,
  input  logic [VALUE_BITS-1:0] new_val,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic                  left_vld,
  input  logic [VALUE_BITS-1:0] right_val,
  input  logic                  right_vld,
  output logic [VALUE_BITS-1:0] own_val,
  output logic                  own_vld
);
  import mot_pkg::*;

  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  vld_r, vld_nxt;
  logic                  ge_own, ge_left, ge_right;

  // A pending clear makes the whole chain look empty to its neighbors.
  assign own_val = val_r;
  assign own_vld = vld_r & ~cmd.clr;

  assign ge_own   = own_vld   && (val_r     >= new_val);
  assign ge_left  = left_vld  && (left_val  >= new_val);
  assign ge_right = right_vld && (right_val >= new_val);

  always_comb begin
    val_nxt = val_r;
    vld_nxt = own_vld;
    case (cmd.op)
      OP_INSERT: begin
        // Larger entries stay, the new cost lands at the boundary, the rest shift right.
        if (ge_own) begin
          val_nxt = val_r;
        end else if (ge_left) begin
          val_nxt = new_val;
        end else begin
          val_nxt = left_val;
        end
        vld_nxt = own_vld | left_vld;
      end
      OP_REPLACE: begin
        // The head leaves: entries shift left until the new cost fits in.
        if (ge_right) begin
          val_nxt = right_val;
        end else if (ge_own) begin
          val_nxt = new_val;
        end else begin
          val_nxt = val_r;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== hdl/max_on_time_purchases.sv =====
// Greedy maximum on-time purchase selector over a sorted chain of cost cells.
// The accepted item waits in the item register; its outcome enters the result register once that is free.
// The item register takes no new item until the cell chain has applied the current one,
// since each update of the chain needs the previous total.
// Reset (synchronous, rst_n low) empties the chain valid bits, total, count and
// both handshakes at once; no clearing pass is needed. Depends on mot_pkg and mot_cell.
`timescale 1ns / 1ps
`include "max_on_time_purchases_defines.svh"
module max_on_time_purchases #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata: deadline_day [15:0], item_cost [31:16]
  input  logic [mot_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: new_list [0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata: taken_count [6:0], total_spent [22:7], zero pad [23]
  output logic [mot_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // out_tuser: action [1:0], overflow [2]
  output logic [mot_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import mot_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  // The accepted item waits here for its update cycle.
  logic                  busy_r;
  logic                  new_list_r;
  logic [VALUE_BITS-1:0] day_r;
  logic [VALUE_BITS-1:0] cost_r;

  // Running selection state.
  logic [VALUE_BITS-1:0] total_r, total_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  // Output register; it parts the result side from the item register.
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TUSER_W-1:0] out_tuser_r;

  logic                  in_xfer;
  logic                  apply;
  cell_cmd_t             cmd;
  logic [1:0]            op_sel;
  logic [1:0]            action;
  logic                  ovf;
  logic [VALUE_BITS-1:0] total_eff;
  logic [CNT_W-1:0]      count_eff;
  logic [VALUE_BITS:0]   need;
  logic                  fits;

  logic [VALUE_BITS-1:0] cell_val [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]  cell_vld;

  assign in_tready = ~busy_r;
  assign in_xfer   = in_tvalid & in_tready;
  // The chain updates once the result register can take the outcome.
  assign apply     = busy_r & (~out_tvalid_r | out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_xfer) begin
      busy_r <= 1'b1;
    end else if (apply) begin
      busy_r <= 1'b0;
    end
  end

  // Fields are taken at VALUE_BITS; the casts truncate or zero-extend.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      new_list_r <= in_tuser;
      day_r      <= VALUE_BITS'(in_tdata[FIELD_W-1:0]);
      cost_r     <= VALUE_BITS'(in_tdata[IN_TDATA_W-1:FIELD_W]);
    end
  end

  // A new list starts from an empty selection before this item is judged.
  assign total_eff = new_list_r ? '0 : total_r;
  assign count_eff = new_list_r ? '0 : count_r;
  // Full precision compare, so total plus cost never wraps.
  assign need      = {1'b0, total_eff} + {1'b0, cost_r};
  assign fits      = ({1'b0, day_r} >= need);

  // The chain head cell_val[0] is the dearest chosen cost.
  always_comb begin
    op_sel    = OP_HOLD;
    action    = ACT_REJECT;
    ovf       = 1'b0;
    total_nxt = total_eff;
    count_nxt = count_eff;
    if (fits) begin
      if (count_eff >= CNT_W'(MAX_ITEMS)) begin
        ovf = 1'b1;
      end else begin
        op_sel    = OP_INSERT;
        action    = ACT_ADD;
        total_nxt = total_eff + cost_r;
        count_nxt = count_eff + CNT_W'(1);
      end
    end else if (cell_vld[0] && (cost_r < cell_val[0])) begin
      op_sel    = OP_REPLACE;
      action    = ACT_SWAP;
      total_nxt = total_eff - cell_val[0] + cost_r;
    end
  end

  assign cmd.op  = apply ? op_sel : OP_HOLD;
  assign cmd.clr = apply & new_list_r;

  // Sorted chain: the first cell sees an all-ones sentinel, never smaller than the new cost, on its left,
  // the last cell an empty neighbor on its right.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic [VALUE_BITS-1:0] l_val, r_val;
    logic                  l_vld, r_vld;
    if (i == 0) begin : g_head
      assign l_val = '1;
      assign l_vld = 1'b1;
    end else begin : g_mid
      assign l_val = cell_val[i-1];
      assign l_vld = cell_vld[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign r_val = '0;
      assign r_vld = 1'b0;
    end else begin : g_body
      assign r_val = cell_val[i+1];
      assign r_vld = cell_vld[i+1];
    end
    mot_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .new_val  (cost_r),
      .left_val (l_val),
      .left_vld (l_vld),
      .right_val(r_val),
      .right_vld(r_vld),
      .own_val  (cell_val[i]),
      .own_vld  (cell_vld[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (apply) begin
        total_r      <= total_nxt;
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, TOTAL_OUT_W'(total_nxt), COUNT_OUT_W'(count_nxt)};
      out_tuser_r <= {ovf, action};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // An accepted item blocks the input until its update cycle is done.
  `MOT_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, !in_tready)
  // The count never runs past the chain length.
  `MOT_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_ITEMS))
  // The second cell is valid only behind a valid head, and never holds a larger cost than the head.
  `MOT_ASSERT_IMPL(a_chain_sorted, clk, rst_n, cell_vld[1], cell_vld[0] && (cell_val[0] >= cell_val[1]))
  // A full-store refusal always reports a rejected item.
  `MOT_ASSERT_IMPL(a_ovf_reject, clk, rst_n, out_tvalid_r && out_tuser_r[ACTION_W], out_tuser_r[ACTION_W-1:0] == ACT_REJECT)

endmodule
